### design/spf_pkg.sv
// Shared constants for the scanline polygon fill block.
package spf_pkg;

   localparam int MAX_VERTICES_DEF = 32;
   localparam int ROW_COUNT_DEF = 1024;
   localparam int FRAC_BITS_DEF = 16;

   localparam int X_INT_BITS = 12;
   localparam int Y_BITS = 10;
   localparam int MAX_SPANS = 16;

   localparam logic ACT_ADD_VERTEX = 1'b0;
   localparam logic ACT_ADVANCE = 1'b1;

endpackage

### design/spf_ram.sv
// Generic single write port RAM with one registered read port.
module spf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### design/spf_div.sv
// Restoring divider that produces one quotient bit per cycle.
module spf_div #(
   parameter int NUM_W = 28,
   parameter int DEN_W = 10
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] numer,
   input  logic [DEN_W-1:0] denom,
   output logic             done,
   output logic [NUM_W-1:0] quot
);

   localparam int CW = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   diff;

   always_comb begin
      trial = {rem_ff, quo_ff[NUM_W-1]};
      diff = trial - {1'b0, den_ff};
      quo_in = quo_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in = numer;
         rem_in = '0;
         den_in = denom;
         cnt_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = diff[DEN_W-1:0];
            quo_in = {quo_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DEN_W-1:0];
            quo_in = {quo_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quot = quo_ff;

endmodule

### design/scanline_polygon_fill_core.sv
// Scanline polygon fill core: vertex store, edge table build and row scan sequencer.
// A vertex beat without close is stored while idle. A close builds the edge table with a
// shared bit-serial divider, one division per non-horizontal edge.
// An advance beat runs an activation pass, selection passes and a step pass over the
// table edges, each pass reading the edge memory one entry at a time.
// Reset (synchronous, active high) clears the control state; the stores stay unwritten.
module scanline_polygon_fill_core #(
   parameter int MAX_VERTICES = spf_pkg::MAX_VERTICES_DEF,
   parameter int ROW_COUNT = spf_pkg::ROW_COUNT_DEF,
   parameter int FRAC_BITS = spf_pkg::FRAC_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic         req_action,
   input  logic [11:0]  req_vertex_x,
   input  logic [9:0]   req_vertex_y,
   input  logic         req_close_polygon,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [9:0]   rsp_row_y,
   output logic [11:0]  rsp_span_start,
   output logic [11:0]  rsp_span_end,
   output logic         rsp_span_valid,
   output logic         rsp_last_of_row,
   output logic         rsp_done_res
);

   // Widths that follow from the parameters.
   localparam int XIB = spf_pkg::X_INT_BITS;
   localparam int YB = spf_pkg::Y_BITS;
   localparam int VCW = $clog2(MAX_VERTICES + 1);
   localparam int VIW = $clog2(MAX_VERTICES);
   localparam int XW = XIB + FRAC_BITS;
   localparam int SW = XW + 1;
   localparam int VW = XIB + YB;
   localparam int EW = 2 * YB + XW + SW;
   localparam int KW = XW + SW + VIW;
   localparam int RCW = 13;
   localparam int NRW = $clog2(spf_pkg::MAX_SPANS + 1);

   // Sequencer states.
   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_BLD_RD = 4'd1;
   localparam logic [3:0] S_BLD_WT = 4'd2;
   localparam logic [3:0] S_EDGE   = 4'd3;
   localparam logic [3:0] S_DIV    = 4'd4;
   localparam logic [3:0] S_BLD_NX = 4'd5;
   localparam logic [3:0] S_ACT_RD = 4'd6;
   localparam logic [3:0] S_ACT_WT = 4'd7;
   localparam logic [3:0] S_SEL_RD = 4'd8;
   localparam logic [3:0] S_SEL_WT = 4'd9;
   localparam logic [3:0] S_SEL_END = 4'd10;
   localparam logic [3:0] S_STP_RD = 4'd11;
   localparam logic [3:0] S_STP_WT = 4'd12;
   localparam logic [3:0] S_FIN    = 4'd13;
   localparam logic [3:0] S_NOSCAN = 4'd14;

   logic [3:0]              state_ff, state_in;
   logic [VCW-1:0]          vcount_ff, vcount_in;
   logic [VCW-1:0]          bn_ff, bn_in;
   logic [VCW-1:0]          etotal_ff, etotal_in;
   logic [VCW-1:0]          idx_ff, idx_in;
   logic [MAX_VERTICES-1:0] active_ff, active_in;
   logic [YB-1:0]           row_ff, row_in;
   logic                    scanning_ff, scanning_in;
   logic [YB-1:0]           lowest_ff, lowest_in;
   logic [VW-1:0]           first_v_ff, first_v_in;
   logic [VW-1:0]           prev_v_ff, prev_v_in;
   logic [VW-1:0]           cur_v_ff, cur_v_in;
   logic                    closing_ff, closing_in;
   logic [YB-1:0]           elow_ff, elow_in;
   logic [YB-1:0]           ehigh_ff, ehigh_in;
   logic [XIB-1:0]          exl_ff, exl_in;
   logic                    eneg_ff, eneg_in;
   logic                    any_ff, any_in;
   logic                    first_round_ff, first_round_in;
   logic                    found_ff, found_in;
   logic [KW-1:0]           best_key_ff, best_key_in;
   logic [KW-1:0]           prev_key_ff, prev_key_in;
   logic                    pair_half_ff, pair_half_in;
   logic [XIB-1:0]          pair_s_ff, pair_s_in;
   logic                    pend_valid_ff, pend_valid_in;
   logic [XIB-1:0]          pend_s_ff, pend_s_in;
   logic [XIB-1:0]          pend_e_ff, pend_e_in;
   logic [NRW-1:0]          nres_ff, nres_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [YB-1:0]           rsp_row_ff, rsp_row_in;
   logic [XIB-1:0]          rsp_start_ff, rsp_start_in;
   logic [XIB-1:0]          rsp_end_ff, rsp_end_in;
   logic                    rsp_span_ff, rsp_span_in;
   logic                    rsp_last_ff, rsp_last_in;
   logic                    rsp_done_ff, rsp_done_in;

   // Memory ports and divider hookup.
   logic           v_we;
   logic [VIW-1:0] v_waddr;
   logic [VW-1:0]  v_wdata;
   logic [VIW-1:0] v_raddr;
   logic [VW-1:0]  v_rdata;
   logic           e_we;
   logic [VIW-1:0] e_waddr;
   logic [EW-1:0]  e_wdata;
   logic [VIW-1:0] e_raddr;
   logic [EW-1:0]  e_rdata;
   logic           div_start;
   logic [XW-1:0]  div_num;
   logic           div_done;
   logic [XW-1:0]  div_quo;

   // Fields of the edge word read back from memory.
   logic [YB-1:0]  rd_low;
   logic [YB-1:0]  rd_high;
   logic [XW-1:0]  rd_x;
   logic [SW-1:0]  rd_slope;
   logic [KW-1:0]  rd_key;
   logic [VIW-1:0] idx_lo;
   logic           idx_last;
   logic [YB:0]    row_p1;
   logic [RCW-1:0] row_next13;
   logic           out_free;
   logic           req_take;

   // Edge build helpers.
   logic [XIB-1:0] ea_x, eb_x;
   logic [YB-1:0]  ea_y, eb_y;
   logic [YB-1:0]  dy;
   logic [XIB-1:0] mag;
   logic [SW-1:0]  slope_new;

   // Span rounding and stepping helpers.
   logic [XW:0]    round_sum;
   logic [XIB-1:0] best_round;
   logic [SW:0]    step_sum;
   logic [XW-1:0]  step_x;
   logic           cand;

   spf_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_vtx_ram (
      .clock   (clock),
      .wr_en   (v_we),
      .wr_addr (v_waddr),
      .wr_data (v_wdata),
      .rd_addr (v_raddr),
      .rd_data (v_rdata)
   );

   spf_ram #(.WIDTH(EW), .DEPTH(MAX_VERTICES)) u_edge_ram (
      .clock   (clock),
      .wr_en   (e_we),
      .wr_addr (e_waddr),
      .wr_data (e_wdata),
      .rd_addr (e_raddr),
      .rd_data (e_rdata)
   );

   spf_div #(.NUM_W(XW), .DEN_W(YB)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (div_num),
      .denom (dy),
      .done  (div_done),
      .quot  (div_quo)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign req_take = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Edge word layout, low to high: slope, start x, upper y, lower y.
   assign rd_slope = e_rdata[SW-1:0];
   assign rd_x = e_rdata[SW+XW-1:SW];
   assign rd_high = e_rdata[SW+XW+YB-1:SW+XW];
   assign rd_low = e_rdata[EW-1:SW+XW+YB];

   assign idx_lo = idx_ff[VIW-1:0];
   assign idx_last = (VCW'(idx_ff + 1'b1) == etotal_ff);
   assign row_p1 = {1'b0, row_ff} + 1'b1;
   assign row_next13 = RCW'(row_ff) + 1'b1;

   // The sort key orders by x, then signed slope (sign flipped), then table index.
   assign rd_key = {rd_x, ~rd_slope[SW-1], rd_slope[SW-2:0], idx_lo};

   // The previous and current vertices form the edge under construction.
   assign ea_x = prev_v_ff[VW-1:YB];
   assign ea_y = prev_v_ff[YB-1:0];
   assign eb_x = cur_v_ff[VW-1:YB];
   assign eb_y = cur_v_ff[YB-1:0];
   assign dy = ehigh_ff - elow_ff;
   assign mag = eneg_ff ? (exl_ff - (ea_y < eb_y ? eb_x : ea_x))
                        : ((ea_y < eb_y ? eb_x : ea_x) - exl_ff);
   assign div_num = {mag, {FRAC_BITS{1'b0}}} + XW'(dy[YB-1:1]);
   assign slope_new = eneg_ff ? (SW'(0) - {1'b0, div_quo}) : {1'b0, div_quo};

   // Round half up, saturated to the last pixel column.
   assign round_sum = {1'b0, best_key_ff[KW-1:KW-XW]} + (XW+1)'(1 << (FRAC_BITS - 1));
   assign best_round = round_sum[XW] ? {XIB{1'b1}} : round_sum[XW-1:FRAC_BITS];

   // Step x by the slope and clamp it to the representable range.
   assign step_sum = {2'b00, rd_x} + {rd_slope[SW-1], rd_slope};
   assign step_x = step_sum[SW] ? '0 : (step_sum[XW] ? {XW{1'b1}} : step_sum[XW-1:0]);

   assign cand = active_ff[idx_lo] && (first_round_ff || (rd_key > prev_key_ff))
                 && (!found_ff || (rd_key < best_key_ff));

   always_comb begin
      state_in = state_ff;
      vcount_in = vcount_ff;
      bn_in = bn_ff;
      etotal_in = etotal_ff;
      idx_in = idx_ff;
      active_in = active_ff;
      row_in = row_ff;
      scanning_in = scanning_ff;
      lowest_in = lowest_ff;
      first_v_in = first_v_ff;
      prev_v_in = prev_v_ff;
      cur_v_in = cur_v_ff;
      closing_in = closing_ff;
      elow_in = elow_ff;
      ehigh_in = ehigh_ff;
      exl_in = exl_ff;
      eneg_in = eneg_ff;
      any_in = any_ff;
      first_round_in = first_round_ff;
      found_in = found_ff;
      best_key_in = best_key_ff;
      prev_key_in = prev_key_ff;
      pair_half_in = pair_half_ff;
      pair_s_in = pair_s_ff;
      pend_valid_in = pend_valid_ff;
      pend_s_in = pend_s_ff;
      pend_e_in = pend_e_ff;
      nres_in = nres_ff;

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_row_in = rsp_row_ff;
      rsp_start_in = rsp_start_ff;
      rsp_end_in = rsp_end_ff;
      rsp_span_in = rsp_span_ff;
      rsp_last_in = rsp_last_ff;
      rsp_done_in = rsp_done_ff;

      v_we = 1'b0;
      v_waddr = vcount_ff[VIW-1:0];
      v_wdata = {req_vertex_x, req_vertex_y};
      v_raddr = idx_lo;
      e_we = 1'b0;
      e_waddr = etotal_ff[VIW-1:0];
      e_wdata = {elow_ff, ehigh_ff, exl_ff, {FRAC_BITS{1'b0}}, slope_new};
      e_raddr = idx_lo;
      div_start = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               if (req_action == spf_pkg::ACT_ADD_VERTEX) begin
                  bn_in = vcount_ff;
                  if (vcount_ff < VCW'(MAX_VERTICES)) begin
                     v_we = 1'b1;
                     vcount_in = vcount_ff + 1'b1;
                     bn_in = vcount_ff + 1'b1;
                  end
                  if (req_close_polygon) begin
                     active_in = '0;
                     etotal_in = '0;
                     idx_in = '0;
                     closing_in = 1'b0;
                     state_in = S_BLD_RD;
                  end
               end else if (!scanning_ff) begin
                  state_in = S_NOSCAN;
               end else begin
                  idx_in = '0;
                  any_in = 1'b0;
                  state_in = S_ACT_RD;
               end
            end
         end
         S_BLD_RD: begin
            state_in = S_BLD_WT;
         end
         S_BLD_WT: begin
            if (idx_ff == '0) begin
               first_v_in = v_rdata;
               prev_v_in = v_rdata;
               if (bn_ff == VCW'(1)) begin
                  cur_v_in = v_rdata;
                  closing_in = 1'b1;
                  state_in = S_EDGE;
               end else begin
                  idx_in = VCW'(1);
                  state_in = S_BLD_RD;
               end
            end else begin
               cur_v_in = v_rdata;
               state_in = S_EDGE;
            end
         end
         S_EDGE: begin
            // Order the end points by y; a horizontal edge is skipped.
            if (ea_y < eb_y) begin
               elow_in = ea_y;
               ehigh_in = eb_y;
               exl_in = ea_x;
               eneg_in = (eb_x < ea_x);
            end else begin
               elow_in = eb_y;
               ehigh_in = ea_y;
               exl_in = eb_x;
               eneg_in = (ea_x < eb_x);
            end
            state_in = (ea_y == eb_y) ? S_BLD_NX : S_DIV;
         end
         S_DIV: begin
            if (!found_ff) begin
               div_start = 1'b1;
               found_in = 1'b1;
            end else if (div_done) begin
               found_in = 1'b0;
               e_we = 1'b1;
               etotal_in = etotal_ff + 1'b1;
               if (etotal_ff == '0 || elow_ff < lowest_ff) begin
                  lowest_in = elow_ff;
               end
               state_in = S_BLD_NX;
            end
         end
         S_BLD_NX: begin
            if (closing_ff) begin
               vcount_in = '0;
               scanning_in = (etotal_ff != '0);
               if (etotal_ff != '0) begin
                  row_in = lowest_ff;
               end
               state_in = S_IDLE;
            end else begin
               prev_v_in = cur_v_ff;
               if (VCW'(idx_ff + 1'b1) == bn_ff) begin
                  closing_in = 1'b1;
                  cur_v_in = first_v_ff;
                  state_in = S_EDGE;
               end else begin
                  idx_in = idx_ff + 1'b1;
                  state_in = S_BLD_RD;
               end
            end
         end
         S_ACT_RD: begin
            state_in = S_ACT_WT;
         end
         S_ACT_WT: begin
            if (active_ff[idx_lo] || rd_low == row_ff) begin
               active_in[idx_lo] = 1'b1;
               if ({1'b0, rd_high} > row_p1) begin
                  any_in = 1'b1;
               end
            end
            if (idx_last) begin
               idx_in = '0;
               first_round_in = 1'b1;
               found_in = 1'b0;
               pair_half_in = 1'b0;
               pend_valid_in = 1'b0;
               nres_in = '0;
               state_in = S_SEL_RD;
            end else begin
               idx_in = idx_ff + 1'b1;
               state_in = S_ACT_RD;
            end
         end
         S_SEL_RD: begin
            state_in = S_SEL_WT;
         end
         S_SEL_WT: begin
            if (cand) begin
               best_key_in = rd_key;
               found_in = 1'b1;
            end
            if (idx_last) begin
               state_in = S_SEL_END;
            end else begin
               idx_in = idx_ff + 1'b1;
               state_in = S_SEL_RD;
            end
         end
         S_SEL_END: begin
            if (!found_ff) begin
               idx_in = '0;
               state_in = S_STP_RD;
            end else if (!pair_half_ff) begin
               pair_s_in = best_round;
               pair_half_in = 1'b1;
               prev_key_in = best_key_ff;
               first_round_in = 1'b0;
               found_in = 1'b0;
               idx_in = '0;
               state_in = S_SEL_RD;
            end else if (pair_s_ff < best_round && nres_ff < NRW'(spf_pkg::MAX_SPANS)) begin
               // A new span pushes the held one out; wait while the output is busy.
               if (!pend_valid_ff || out_free) begin
                  if (pend_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_row_in = row_ff;
                     rsp_start_in = pend_s_ff;
                     rsp_end_in = pend_e_ff;
                     rsp_span_in = 1'b1;
                     rsp_last_in = 1'b0;
                     rsp_done_in = !any_ff;
                  end
                  pend_valid_in = 1'b1;
                  pend_s_in = pair_s_ff;
                  pend_e_in = best_round;
                  nres_in = nres_ff + 1'b1;
                  pair_half_in = 1'b0;
                  prev_key_in = best_key_ff;
                  found_in = 1'b0;
                  idx_in = '0;
                  state_in = S_SEL_RD;
               end
            end else begin
               pair_half_in = 1'b0;
               prev_key_in = best_key_ff;
               found_in = 1'b0;
               idx_in = '0;
               state_in = S_SEL_RD;
            end
         end
         S_STP_RD: begin
            state_in = S_STP_WT;
         end
         S_STP_WT: begin
            if (active_ff[idx_lo]) begin
               e_we = 1'b1;
               e_waddr = idx_lo;
               e_wdata = {rd_low, rd_high, step_x, rd_slope};
               if ({1'b0, rd_high} <= row_p1) begin
                  active_in[idx_lo] = 1'b0;
               end
            end
            if (idx_last) begin
               state_in = S_FIN;
            end else begin
               idx_in = idx_ff + 1'b1;
               state_in = S_STP_RD;
            end
         end
         S_FIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_row_in = row_ff;
               rsp_start_in = pend_valid_ff ? pend_s_ff : '0;
               rsp_end_in = pend_valid_ff ? pend_e_ff : '0;
               rsp_span_in = pend_valid_ff;
               rsp_last_in = 1'b1;
               rsp_done_in = !any_ff;
               if (!any_ff) begin
                  scanning_in = 1'b0;
               end
               row_in = (row_next13 == RCW'(ROW_COUNT)) ? '0 : row_next13[YB-1:0];
               state_in = S_IDLE;
            end
         end
         S_NOSCAN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_row_in = row_ff;
               rsp_start_in = '0;
               rsp_end_in = '0;
               rsp_span_in = 1'b0;
               rsp_last_in = 1'b1;
               rsp_done_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         vcount_ff <= '0;
         etotal_ff <= '0;
         active_ff <= '0;
         row_ff <= '0;
         scanning_ff <= 1'b0;
         found_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         vcount_ff <= vcount_in;
         etotal_ff <= etotal_in;
         active_ff <= active_in;
         row_ff <= row_in;
         scanning_ff <= scanning_in;
         found_ff <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      bn_ff <= bn_in;
      idx_ff <= idx_in;
      lowest_ff <= lowest_in;
      first_v_ff <= first_v_in;
      prev_v_ff <= prev_v_in;
      cur_v_ff <= cur_v_in;
      closing_ff <= closing_in;
      elow_ff <= elow_in;
      ehigh_ff <= ehigh_in;
      exl_ff <= exl_in;
      eneg_ff <= eneg_in;
      any_ff <= any_in;
      first_round_ff <= first_round_in;
      best_key_ff <= best_key_in;
      prev_key_ff <= prev_key_in;
      pair_half_ff <= pair_half_in;
      pair_s_ff <= pair_s_in;
      pend_valid_ff <= pend_valid_in;
      pend_s_ff <= pend_s_in;
      pend_e_ff <= pend_e_in;
      nres_ff <= nres_in;
      rsp_row_ff <= rsp_row_in;
      rsp_start_ff <= rsp_start_in;
      rsp_end_ff <= rsp_end_in;
      rsp_span_ff <= rsp_span_in;
      rsp_last_ff <= rsp_last_in;
      rsp_done_ff <= rsp_done_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_row_y = rsp_row_ff;
   assign rsp_span_start = rsp_start_ff;
   assign rsp_span_end = rsp_end_ff;
   assign rsp_span_valid = rsp_span_ff;
   assign rsp_last_of_row = rsp_last_ff;
   assign rsp_done_res = rsp_done_ff;

endmodule

### design/spf_checker.sv
// Port-level checks for the scanline polygon fill core, bound to the top level.
module spf_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        req_action,
   input logic [11:0] req_vertex_x,
   input logic [9:0]  req_vertex_y,
   input logic        req_close_polygon,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [9:0]  rsp_row_y,
   input logic [11:0] rsp_span_start,
   input logic [11:0] rsp_span_end,
   input logic        rsp_span_valid,
   input logic        rsp_last_of_row,
   input logic        rsp_done_res
);

   // A stalled result beat holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_span_start)
         && $stable(rsp_span_end) && $stable(rsp_row_y))
      else $error("stalled result beat changed");

   // A span is never empty.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_span_valid |-> rsp_span_start < rsp_span_end)
      else $error("empty span delivered");

   // A beat without a span closes its row and carries zero ends.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_span_valid |-> rsp_last_of_row && rsp_span_start == 12'd0
         && rsp_span_end == 12'd0)
      else $error("spanless beat malformed");

   // An advance keeps the block busy on the following cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_action == spf_pkg::ACT_ADVANCE |=> req_stall)
      else $error("advance accepted without busy");

endmodule

bind scanline_polygon_fill_core spf_checker u_spf_checker (.*);
